[hdl/ecg_pkg.sv]
// shared types, constants and arithmetic helpers of the ecg r-peak heart-rate block
package ecg_pkg;

  localparam int DC_WINDOW_LEN = 256;
  localparam int DC_LOG = $clog2(DC_WINDOW_LEN);
  localparam int SAMPLE_W = 13;
  localparam int SUM_W = SAMPLE_W + DC_LOG;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RR_MIN = 2'd0,
    REG_RR_MAX = 2'd1,
    REG_TH_FLOOR = 2'd2,
    REG_BPM_SCALE = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    C_B0,
    C_B1,
    C_B2,
    C_A1,
    C_A2
  } coef_sel_t;

  localparam logic signed [31:0] TH_RESET = 32'sd819200;
  localparam logic signed [33:0] OFFSET_50 = 34'sd204800;
  localparam logic signed [23:0] K_07 = 24'sd2936013;
  localparam logic signed [23:0] K_03 = 24'sd1258291;
  localparam logic signed [23:0] K_DECAY = 24'sd4193885;

  function automatic logic signed [23:0] coef(input logic [1:0] stg, input coef_sel_t sel);
    logic signed [23:0] c;
    c = '0;
    unique case (stg)
      2'd0: begin
        unique case (sel)
          C_B0: c = 24'sd4125179;
          C_B1: c = -24'sd4420763;
          C_B2: c = 24'sd4125179;
          C_A1: c = -24'sd4420763;
          C_A2: c = 24'sd4056055;
          default: c = '0;
        endcase
      end
      2'd1: begin
        unique case (sel)
          C_B0: c = 24'sd282928;
          C_B1: c = 24'sd565856;
          C_B2: c = 24'sd282928;
          C_A1: c = -24'sd4794008;
          C_A2: c = 24'sd1731415;
          default: c = '0;
        endcase
      end
      2'd2: begin
        unique case (sel)
          C_B0: c = 24'sd282907;
          C_B1: c = 24'sd565815;
          C_B2: c = 24'sd282907;
          C_A1: c = -24'sd4793660;
          C_A2: c = 24'sd1730985;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_sat(input logic signed [59:0] v,
                                                 input logic signed [31:0] add);
    logic signed [59:0] r;
    logic signed [59:0] s;
    logic signed [39:0] t;
    r = v + 60'sd2097152;
    s = r >>> 22;
    t = s[39:0] + 40'(add);
    return sat32(t);
  endfunction

endpackage

[hdl/ecg_in_if.sv]
// sample request channel
interface ecg_in_if;
  logic valid;
  logic ready;
  logic signed [ecg_pkg::SAMPLE_W-1:0] ecg_sample;
  modport source (output valid, output ecg_sample, input ready);
  modport sink (input valid, input ecg_sample, output ready);
endinterface

[hdl/ecg_out_if.sv]
// result request channel
interface ecg_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] filtered_value;
  logic [7:0] heart_rate_bpm;
  modport source (output valid, output filtered_value, output heart_rate_bpm, input ready);
  modport sink (input valid, input filtered_value, input heart_rate_bpm, output ready);
endinterface

[hdl/ecg_ram.sv]
// generic single-write single-read ram with registered read
module ecg_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ecg_div.sv]
// restoring serial divider, one quotient bit per cycle
module ecg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [32:0] trial;

  assign trial = {rem[31:0], quotient[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= '0;
        dvs <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quotient <= {quotient[14:0], 1'b1};
        end else begin
          rem <= trial;
          quotient <= {quotient[14:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/ecg_filter_rpeak_heart_rate.sv]
// ecg conditioning, biquad filtering and r-peak heart-rate detector, top level
//
// One ecg sample comes in on in_ch, one result leaves on out_ch per sample: the
// filtered value (signed Q20.12) and the heart rate in bpm on a valid beat, else 0.
// Registers are written through cfg_we / cfg_index / cfg_data, by the user only
// while idle: the block does not enforce it. A sample runs through a small
// sequencer around one shared 34x24 multiplier: dc removal, three biquads, then
// the detector with the output step, or on a valid beat the detector with the
// 16-step serial divider for the bpm; a new sample is taken only once the last
// one has reached the output register; in_ch.ready is high only between samples.
// The result sits in an output register, so a new sample is taken while it
// waits; a stalled receiver holds the sequencer only at the end of the next one.
// After reset the dc window ram is cleared, one entry a cycle, all
// DC_WINDOW_LEN (256) entries, during which no sample is taken; registers
// return to their defaults and the detector threshold to 200.0.
module ecg_filter_rpeak_heart_rate (
  input  logic                               clk,
  input  logic                               rst,
  ecg_in_if.sink                             in_ch,
  ecg_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [ecg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ecg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DC_SUM, S_DC_X,
    S_M0, S_Y, S_M1, S_A1, S_D0, S_A2, S_D1,
    S_T_P, S_T_B1, S_T_B2, S_T_DEC, S_T_DEC2, S_T_FLOOR, S_DIV, S_FIN
  } state_t;

  state_t state;

  logic [15:0] rr_min;
  logic [15:0] rr_max;
  logic [11:0] th_floor;
  logic [15:0] bpm_scale;

  logic [ecg_pkg::DC_LOG-1:0]                clr;
  logic [ecg_pkg::DC_LOG-1:0]                pos;
  logic signed [ecg_pkg::SAMPLE_W-1:0]       s;
  logic signed [ecg_pkg::SUM_W-1:0]          sum;
  logic [ecg_pkg::SAMPLE_W-1:0]              ram_rdata;
  logic                                      ram_we;
  logic [ecg_pkg::DC_LOG-1:0]                ram_waddr;
  logic [ecg_pkg::SAMPLE_W-1:0]              ram_wdata;

  logic signed [31:0] xr;
  logic signed [31:0] y;
  logic signed [31:0] d [6];
  logic signed [31:0] d0_new;
  logic [1:0]         stg;

  logic signed [33:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [57:0] prod;
  logic signed [59:0] acc;

  logic signed [31:0] th;
  logic signed [31:0] pk;
  logic [31:0]        sc;
  logic [31:0]        last;
  logic [31:0]        rr;
  logic [7:0]         bpm;

  logic               ov;
  logic signed [31:0] out_val;
  logic [7:0]         out_bpm;

  logic               div_start;
  logic               div_done;
  logic [15:0]        div_q;

  logic signed [ecg_pkg::SUM_W+11:0] dc_v;
  logic signed [ecg_pkg::SUM_W+11:0] dc_mean;
  logic signed [ecg_pkg::SUM_W+11:0] dc_bias;
  logic signed [31:0] pk_upd;
  logic signed [32:0] x2;
  logic               beat;

  ecg_ram #(
    .WIDTH(ecg_pkg::SAMPLE_W),
    .DEPTH(ecg_pkg::DC_WINDOW_LEN)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(pos),
    .rdata(ram_rdata)
  );

  ecg_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(bpm_scale),
    .divisor(rr),
    .done(div_done),
    .quotient(div_q)
  );

  assign ram_we = (state == S_CLEAR) || (state == S_DC_SUM);
  assign ram_waddr = (state == S_CLEAR) ? clr : pos;
  assign ram_wdata = (state == S_CLEAR) ? '0 : s;

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = ov;
  assign out_ch.filtered_value = out_val;
  assign out_ch.heart_rate_bpm = out_bpm;

  assign div_start = (state == S_T_B2) && (rr > {16'd0, rr_min}) && (rr < {16'd0, rr_max});

  // dc mean, truncated toward zero
  assign dc_v = (ecg_pkg::SUM_W+12)'(sum) <<< 12;
  assign dc_bias = dc_v[ecg_pkg::SUM_W+11] ?
                   (ecg_pkg::SUM_W+12)'(ecg_pkg::DC_WINDOW_LEN - 1) : '0;
  assign dc_mean = (dc_v + dc_bias) >>> ecg_pkg::DC_LOG;

  assign pk_upd = ((xr > th) && (xr > pk)) ? xr : pk;
  assign x2 = 33'(xr) <<< 1;
  assign beat = (pk_upd > th) && (x2 < 33'(th));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_M0: begin
        mul_a = 34'(xr);
        mul_b = ecg_pkg::coef(stg, ecg_pkg::C_B0);
      end
      S_M1: begin
        mul_a = 34'(xr);
        mul_b = ecg_pkg::coef(stg, ecg_pkg::C_B1);
      end
      S_A1: begin
        mul_a = 34'(y);
        mul_b = ecg_pkg::coef(stg, ecg_pkg::C_A1);
      end
      S_D0: begin
        mul_a = 34'(xr);
        mul_b = ecg_pkg::coef(stg, ecg_pkg::C_B2);
      end
      S_A2: begin
        mul_a = 34'(y);
        mul_b = ecg_pkg::coef(stg, ecg_pkg::C_A2);
      end
      S_T_P: begin
        mul_a = 34'(th);
        mul_b = ecg_pkg::K_07;
      end
      S_T_B1: begin
        mul_a = 34'(xr) + ecg_pkg::OFFSET_50;
        mul_b = ecg_pkg::K_03;
      end
      S_T_DEC: begin
        mul_a = 34'(th);
        mul_b = ecg_pkg::K_DECAY;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 58'(mul_a) * 58'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rr_min <= 16'd68;
      rr_max <= 16'd500;
      th_floor <= 12'd50;
      bpm_scale <= 16'd15000;
    end else if (cfg_we) begin
      unique case (ecg_pkg::cfg_reg_t'(cfg_index))
        ecg_pkg::REG_RR_MIN: rr_min <= cfg_data;
        ecg_pkg::REG_RR_MAX: rr_max <= cfg_data;
        ecg_pkg::REG_TH_FLOOR: th_floor <= cfg_data[11:0];
        ecg_pkg::REG_BPM_SCALE: bpm_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      pos <= '0;
      sum <= '0;
      for (int i = 0; i < 6; i++) d[i] <= '0;
      th <= ecg_pkg::TH_RESET;
      pk <= '0;
      sc <= '0;
      last <= '0;
      stg <= '0;
      ov <= 1'b0;
    end else begin
      if ((state != S_FIN) && out_ch.valid && out_ch.ready) ov <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == ecg_pkg::DC_LOG'(ecg_pkg::DC_WINDOW_LEN - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            s <= in_ch.ecg_sample;
            state <= S_DC_SUM;
          end
        end
        S_DC_SUM: begin
          sum <= sum - ecg_pkg::SUM_W'($signed(ram_rdata)) + ecg_pkg::SUM_W'(s);
          pos <= pos + 1'b1;
          state <= S_DC_X;
        end
        S_DC_X: begin
          xr <= ecg_pkg::sat32((40'(s) <<< 12) - 40'(dc_mean));
          stg <= '0;
          state <= S_M0;
        end
        S_M0: state <= S_Y;
        S_Y: begin
          y <= ecg_pkg::rnd_sat(60'(prod), d[0]);
          state <= S_M1;
        end
        S_M1: state <= S_A1;
        S_A1: begin
          acc <= 60'(prod);
          state <= S_D0;
        end
        S_D0: begin
          d0_new <= ecg_pkg::rnd_sat(acc - 60'(prod), d[1]);
          state <= S_A2;
        end
        S_A2: begin
          acc <= 60'(prod);
          state <= S_D1;
        end
        S_D1: begin
          // rotate so the next stage's delays sit in d[0], d[1]
          d[0] <= d[2];
          d[1] <= d[3];
          d[2] <= d[4];
          d[3] <= d[5];
          d[4] <= d0_new;
          d[5] <= ecg_pkg::rnd_sat(acc - 60'(prod), '0);
          xr <= y;
          if (stg == 2'd2) begin
            state <= S_T_P;
          end else begin
            stg <= stg + 2'd1;
            state <= S_M0;
          end
        end
        S_T_P: begin
          sc <= sc + 32'd1;
          rr <= sc + 32'd1 - last;
          bpm <= '0;
          if (beat) begin
            last <= sc + 32'd1;
            pk <= '0;
            state <= S_T_B1;
          end else begin
            pk <= pk_upd;
            state <= S_T_DEC;
          end
        end
        S_T_B1: begin
          acc <= 60'(prod);
          state <= S_T_B2;
        end
        S_T_B2: begin
          th <= ecg_pkg::rnd_sat(acc + 60'(prod), '0);
          state <= div_start ? S_DIV : S_T_DEC;
        end
        S_T_DEC: begin
          state <= (pk == '0) ? S_T_DEC2 : S_T_FLOOR;
        end
        S_T_DEC2: begin
          th <= ecg_pkg::rnd_sat(60'(prod), '0);
          state <= S_T_FLOOR;
        end
        S_T_FLOOR: begin
          if (th < $signed({8'd0, th_floor, 12'd0})) th <= $signed({8'd0, th_floor, 12'd0});
          state <= S_FIN;
        end
        S_DIV: begin
          if (div_done) begin
            bpm <= (div_q > 16'd255) ? 8'd255 : div_q[7:0];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!ov || out_ch.ready) begin
            ov <= 1'b1;
            out_val <= xr;
            out_bpm <= bpm;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
